// ----- rtl/rlb_pkg.sv -----
// ----------------------------------------------------------------------------
// rlb_pkg
// Shared types and constants for the RGBA layer blend pipeline.
// ----------------------------------------------------------------------------
package rlb_pkg;

  localparam int MODE_W     = 5;
  localparam int PIPE_DEPTH = 8;

  // Blend mode codes, in register order
  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL   = 5'd0,
    MODE_LIGHTEN  = 5'd1,
    MODE_DARKEN   = 5'd2,
    MODE_MULTIPLY = 5'd3,
    MODE_AVERAGE  = 5'd4,
    MODE_ADD      = 5'd5,
    MODE_SUBTRACT = 5'd6,
    MODE_DIFF     = 5'd7,
    MODE_NEGATION = 5'd8,
    MODE_SCREEN   = 5'd9,
    MODE_EXCLUDE  = 5'd10,
    MODE_OVERLAY  = 5'd11,
    MODE_SOFT     = 5'd12,
    MODE_HARD     = 5'd13,
    MODE_DODGE    = 5'd14,
    MODE_BURN     = 5'd15,
    MODE_LDODGE   = 5'd16,
    MODE_LBURN    = 5'd17,
    MODE_LLIGHT   = 5'd18,
    MODE_VIVID    = 5'd19,
    MODE_PIN      = 5'd20,
    MODE_HARDMIX  = 5'd21,
    MODE_REFLECT  = 5'd22,
    MODE_GLOW     = 5'd23,
    MODE_PHOENIX  = 5'd24
  } mode_t;

  // Configuration register indexes
  localparam logic REG_BLEND_MODE   = 1'b0;
  localparam logic REG_ALPHA_ENABLE = 1'b1;

  // Which unit produces the channel value
  typedef enum logic [1:0] {
    CLS_SIMPLE,
    CLS_MUL,
    CLS_DIV
  } cls_t;

  // Post operation after the product is scaled (by 1/255, or by 1/256 for screen)
  typedef enum logic [1:0] {
    POST_DIRECT,
    POST_INV,
    POST_EXCL,
    POST_SCREEN
  } post_t;

  // Control and side data that travel down the channel pipeline
  typedef struct packed {
    cls_t       cls;
    logic [7:0] base;
    logic [7:0] b;
    logic [7:0] a;
    logic       dinv;
    logic       dhm;
    logic [7:0] den;
  } ctl_t;

endpackage

// ----- rtl/rgba_layer_blend.sv -----
// ----------------------------------------------------------------------------
// rgba_layer_blend
// Per-pixel layer blend for 8-bit RGBA with 25 blend modes.
// ----------------------------------------------------------------------------
// Takes one top/bottom pixel pair per clock and returns the blended pixel.
// The pipeline is fully streaming: one pixel every cycle is sustained, and
// it only halts while a finished pixel waits on out_ready. Dodge, burn,
// vivid light, hard mix, reflect and glow use a restoring quotient unit
// spread two bits per stage over four stages; all divisions by 255 are
// done by reciprocal estimate with a small correction. Write blend_mode
// and alpha_enable only while no pixel is in flight.
module rgba_layer_blend import rlb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [MODE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        top_red,
  input  logic [7:0]        top_green,
  input  logic [7:0]        top_blue,
  input  logic [7:0]        top_alpha,
  input  logic [7:0]        bottom_red,
  input  logic [7:0]        bottom_green,
  input  logic [7:0]        bottom_blue,
  input  logic [7:0]        bottom_alpha,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha
);

  logic [MODE_W-1:0]     blend_mode;
  logic                  alpha_enable;
  logic [PIPE_DEPTH-1:0] vld;
  logic                  en;
  logic [7:0]            alpha_mix;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode   <= MODE_NORMAL;
      alpha_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLEND_MODE:   blend_mode   <= cfg_data;
        REG_ALPHA_ENABLE: alpha_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the output holds an untaken transfer
  assign en       = ~vld[PIPE_DEPTH-1] | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[PIPE_DEPTH-2:0], in_valid};
  end

  assign out_valid = vld[PIPE_DEPTH-1];

  rlb_chan u_red (
    .clk(clk), .en(en), .mode(blend_mode), .alpha_en(alpha_enable),
    .t(top_red), .b(bottom_red), .a(top_alpha), .c(out_red)
  );

  rlb_chan u_green (
    .clk(clk), .en(en), .mode(blend_mode), .alpha_en(alpha_enable),
    .t(top_green), .b(bottom_green), .a(top_alpha), .c(out_green)
  );

  rlb_chan u_blue (
    .clk(clk), .en(en), .mode(blend_mode), .alpha_en(alpha_enable),
    .t(top_blue), .b(bottom_blue), .a(top_alpha), .c(out_blue)
  );

  // Alpha merge reuses the channel path in pass-through mode
  rlb_chan u_alpha (
    .clk(clk), .en(en), .mode(MODE_NORMAL), .alpha_en(alpha_enable),
    .t(top_alpha), .b(bottom_alpha), .a(top_alpha), .c(alpha_mix)
  );

  assign out_alpha = alpha_enable ? alpha_mix : 8'd255;

endmodule

// ----- rtl/rlb_chan.sv -----
// ----------------------------------------------------------------------------
// rlb_chan
// One channel of the blend: mode select, product and quotient units, then
// alpha weighting against the bottom value. Eight register stages.
// ----------------------------------------------------------------------------
module rlb_chan import rlb_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [MODE_W-1:0] mode,
  input  logic              alpha_en,
  input  logic [7:0]        t,
  input  logic [7:0]        b,
  input  logic [7:0]        a,
  output logic [7:0]        c
);

  // x / 255 for x below 2^17: estimate, then correct by up to two
  function automatic logic [8:0] div255(input logic [16:0] x);
    logic [17:0] s;
    logic [9:0]  e;
    logic [17:0] r;
    logic [9:0]  q;
    s = {1'b0, x} + {9'd0, x[16:8]};
    e = s[17:8];
    r = {1'b0, x} - ({e, 8'd0} - {8'd0, e});
    if (r >= 18'd510) q = e + 10'd2;
    else if (r >= 18'd255) q = e + 10'd1;
    else q = e;
    return q[8:0];
  endfunction

  // One restoring division step: {quotient bit, new remainder}
  function automatic logic [8:0] div_step(input logic [7:0] r, input logic nb,
                                          input logic [7:0] den);
    logic [8:0] rr;
    logic [8:0] diff;
    rr   = {r, nb};
    diff = rr - {1'b0, den};
    if (rr >= {1'b0, den}) return {1'b1, diff[7:0]};
    return {1'b0, rr[7:0]};
  endfunction

  // --------------------------------------------------------------------------
  // Stage 1: decode the mode into operands
  // --------------------------------------------------------------------------
  ctl_t       ctl0;
  logic [7:0] mx0, my0, dx0;
  logic       dbl0, k2540, dsq0;
  post_t      post0;
  logic [8:0] s9;
  logic [9:0] ll;
  logic [7:0] d2, m, adiff, ng;
  logic       lo;

  always_comb begin
    s9    = {1'b0, t} + {1'b0, b};
    ll    = {2'b00, t} + {1'b0, b, 1'b0};
    d2    = {b[6:0], 1'b0};
    lo    = ~b[7];
    m     = {1'b0, t[7:1]} + 8'd64;
    adiff = (t >= b) ? (t - b) : (b - t);
    ng    = (s9 >= 9'd255) ? 8'(s9 - 9'd255) : 8'(9'd255 - s9);

    ctl0.cls  = CLS_SIMPLE;
    ctl0.base = t;
    ctl0.b    = b;
    ctl0.a    = a;
    ctl0.dinv = 1'b0;
    ctl0.dhm  = 1'b0;
    ctl0.den  = 8'd0;
    mx0   = t;
    my0   = b;
    dbl0  = 1'b0;
    k2540 = 1'b0;
    post0 = POST_DIRECT;
    dx0   = t;
    dsq0  = 1'b0;

    case (mode)
      MODE_LIGHTEN: ctl0.base = (t > b) ? t : b;
      MODE_DARKEN:  ctl0.base = (t < b) ? t : b;
      MODE_MULTIPLY: ctl0.cls = CLS_MUL;
      MODE_AVERAGE: ctl0.base = s9[8:1];
      MODE_ADD, MODE_LDODGE: ctl0.base = s9[8] ? 8'd255 : s9[7:0];
      MODE_SUBTRACT, MODE_LBURN:
        ctl0.base = (s9 < 9'd255) ? 8'd0 : 8'(s9 - 9'd255);
      MODE_DIFF:     ctl0.base = adiff;
      MODE_NEGATION: ctl0.base = 8'd255 - ng;
      MODE_SCREEN: begin
        ctl0.cls = CLS_MUL;
        mx0 = ~t;
        my0 = ~b;
        post0 = POST_SCREEN;
      end
      MODE_EXCLUDE: begin
        ctl0.cls = CLS_MUL;
        dbl0 = 1'b1;
        post0 = POST_EXCL;
      end
      MODE_OVERLAY: begin
        ctl0.cls = CLS_MUL;
        dbl0 = 1'b1;
        if (!lo) begin
          mx0 = ~t;
          my0 = ~b;
          post0 = POST_INV;
        end
      end
      MODE_HARD: begin
        ctl0.cls = CLS_MUL;
        dbl0 = 1'b1;
        mx0 = b;
        my0 = t;
        if (t[7]) begin
          mx0 = ~b;
          my0 = ~t;
          post0 = POST_INV;
        end
      end
      MODE_SOFT: begin
        ctl0.cls = CLS_MUL;
        dbl0 = 1'b1;
        mx0 = m;
        if (!lo) begin
          mx0 = ~m;
          my0 = ~b;
          k2540 = 1'b1;
          post0 = POST_INV;
        end
      end
      MODE_DODGE: begin
        ctl0.cls = CLS_DIV;
        ctl0.den = ~b;
      end
      MODE_BURN: begin
        ctl0.cls = CLS_DIV;
        dx0 = ~t;
        ctl0.den = b;
        ctl0.dinv = 1'b1;
      end
      MODE_LLIGHT: begin
        if (lo) ctl0.base = (ll < 10'd255) ? 8'd0 : 8'(ll - 10'd255);
        else ctl0.base = (ll >= 10'd511) ? 8'd255 : 8'(ll - 10'd256);
      end
      MODE_VIVID, MODE_HARDMIX: begin
        ctl0.cls = CLS_DIV;
        ctl0.dhm = (mode == MODE_HARDMIX);
        if (lo) begin
          dx0 = ~t;
          ctl0.den = d2;
          ctl0.dinv = 1'b1;
        end else begin
          ctl0.den = ~d2;
        end
      end
      MODE_PIN: begin
        if (lo) ctl0.base = (t < d2) ? t : d2;
        else ctl0.base = (t > d2) ? t : d2;
      end
      MODE_REFLECT: begin
        ctl0.cls = CLS_DIV;
        dsq0 = 1'b1;
        ctl0.den = ~b;
      end
      MODE_GLOW: begin
        ctl0.cls = CLS_DIV;
        dsq0 = 1'b1;
        dx0 = b;
        ctl0.den = ~t;
      end
      MODE_PHOENIX: ctl0.base = 8'd255 - adiff;
      default: ctl0.base = t;
    endcase
  end

  ctl_t       ctl1, ctl2;
  logic [7:0] mx1, my1, dx1;
  logic       dbl1, k2541, dsq1, dbl2, k2542;
  post_t      post1, post2;
  logic [8:0] s91, s92;
  logic [15:0] p2, dnum2;

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1  <= ctl0;
      mx1   <= mx0;
      my1   <= my0;
      dx1   <= dx0;
      dbl1  <= dbl0;
      k2541 <= k2540;
      dsq1  <= dsq0;
      post1 <= post0;
      s91   <= s9;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: products
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      ctl2  <= ctl1;
      p2    <= mx1 * my1;
      dnum2 <= dsq1 ? (dx1 * dx1) : {dx1, 8'd0};
      dbl2  <= dbl1;
      k2542 <= k2541;
      post2 <= post1;
      s92   <= s91;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale product by 1/255 and finish the product modes
  // --------------------------------------------------------------------------
  logic [16:0] px;
  logic [8:0]  v;
  logic [7:0]  mres;
  logic [8:0]  ex;
  ctl_t        ctl2m;

  always_comb begin
    px = (dbl2 ? {p2, 1'b0} : {1'b0, p2}) + (k2542 ? 17'd254 : 17'd0);
    v  = div255(px);
    ex = s92 - v;
    case (post2)
      POST_DIRECT: mres = v[8] ? 8'd255 : v[7:0];
      POST_INV:    mres = v[8] ? 8'd0 : (8'd255 - v[7:0]);
      POST_EXCL:   mres = (s92 < v) ? 8'd0 : (ex[8] ? 8'd255 : ex[7:0]);
      default:     mres = 8'd255 - p2[15:8];
    endcase
    ctl2m = ctl2;
    if (ctl2.cls == CLS_MUL) ctl2m.base = mres;
  end

  // --------------------------------------------------------------------------
  // Stages 3 to 6: quotient, two bits a stage
  // --------------------------------------------------------------------------
  ctl_t       cs  [4];
  logic [7:0] dr  [4];
  logic [7:0] dq  [4];
  logic [7:0] dlo [4];
  logic       dov [4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    ctl_t       ci;
    logic [7:0] ri, qi, li;
    logic       oi;
    logic [8:0] st1, st2;

    if (k == 0) begin : g_first
      assign ci = ctl2m;
      assign ri = dnum2[15:8];
      assign qi = 8'd0;
      assign li = dnum2[7:0];
      assign oi = (dnum2[15:8] >= ctl2.den);
    end else begin : g_rest
      assign ci = cs[k-1];
      assign ri = dr[k-1];
      assign qi = dq[k-1];
      assign li = dlo[k-1];
      assign oi = dov[k-1];
    end

    assign st1 = div_step(ri, li[7-2*k], ci.den);
    assign st2 = div_step(st1[7:0], li[6-2*k], ci.den);

    always_ff @(posedge clk) begin
      if (en) begin
        cs[k]  <= ci;
        dr[k]  <= st2[7:0];
        dq[k]  <= {qi[5:0], st1[8], st2[8]};
        dlo[k] <= li;
        dov[k] <= oi;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: pick the channel value and weight it by alpha
  // --------------------------------------------------------------------------
  logic [7:0]  sat, dv, cv, c7;
  logic [15:0] wa, wb;
  logic [16:0] w7;

  always_comb begin
    sat = dov[3] ? 8'd255 : dq[3];
    dv  = cs[3].dinv ? (8'd255 - sat) : sat;
    if (cs[3].dhm) dv = dv[7] ? 8'd255 : 8'd0;
    cv  = (cs[3].cls == CLS_DIV) ? dv : cs[3].base;
    wa  = {8'd0, cs[3].a} * {8'd0, cv};
    wb  = {8'd0, 8'd255 - cs[3].a} * {8'd0, cs[3].b};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c7 <= cv;
      w7 <= {1'b0, wa} + {1'b0, wb};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: scale the weighted sum
  // --------------------------------------------------------------------------
  logic [8:0] wq;
  assign wq = div255(w7);

  always_ff @(posedge clk) begin
    if (en) c <= alpha_en ? wq[7:0] : c7;
  end

endmodule

// ----- dv/tb_rgba_layer_blend.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgba_layer_blend
// Self-checking bench: per-pixel blend predictor, random handshakes, phases
// over every blend mode with alpha enable varied, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_rgba_layer_blend;
  import rlb_pkg::*;

  typedef struct packed {
    logic [7:0] tr, tg, tb, ta, br, bg, bb, ba;
  } pix_pair_t;

  typedef struct packed {
    logic [7:0] r, g, b, a;
  } pix_out_t;

  localparam int LIMIT = 400000;

  logic clk, rst;
  logic cfg_we, cfg_index;
  logic [MODE_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [7:0] top_red, top_green, top_blue, top_alpha;
  logic [7:0] bottom_red, bottom_green, bottom_blue, bottom_alpha;
  logic [7:0] out_red, out_green, out_blue, out_alpha;

  rgba_layer_blend DUT (.*);

  pix_pair_t pending_q[$];
  pix_out_t  blend_expect_q[$];
  logic [4:0] cur_mode;
  logic       cur_alpha;
  int errors, cycles, hold_left;
  bit hold_req, quiet;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int clip(int v);
    return v < 0 ? 0 : (v > 255 ? 255 : v);
  endfunction

  function automatic int over_ch(int t, int b);
    if (b < 128) return clip(2 * t * b / 255);
    return clip(255 - 2 * (255 - t) * (255 - b) / 255);
  endfunction

  function automatic int dodge_ch(int t, int b);
    if (b == 255) return 255;
    return clip(t * 256 / (255 - b));
  endfunction

  function automatic int burn_ch(int t, int b);
    if (b == 0) return 0;
    return clip(255 - (255 - t) * 256 / b);
  endfunction

  function automatic int refl_ch(int t, int b);
    if (b == 255) return 255;
    return clip(t * t / (255 - b));
  endfunction

  function automatic int vivid_ch(int t, int b);
    if (b < 128) return burn_ch(t, 2 * b);
    return dodge_ch(t, 2 * (b - 128));
  endfunction

  function automatic int mix_channel(logic [4:0] mode, int t, int b);
    int m;
    case (mode)
      MODE_LIGHTEN:  return t > b ? t : b;
      MODE_DARKEN:   return t < b ? t : b;
      MODE_MULTIPLY: return clip(t * b / 255);
      MODE_AVERAGE:  return clip((t + b) / 2);
      MODE_ADD, MODE_LDODGE: return clip(t + b);
      MODE_SUBTRACT, MODE_LBURN: return clip(t + b - 255);
      MODE_DIFF:     return t > b ? t - b : b - t;
      MODE_NEGATION: begin
        m = 255 - t - b;
        return clip(255 - (m < 0 ? -m : m));
      end
      MODE_SCREEN:   return clip(255 - (((255 - t) * (255 - b)) >>> 8));
      MODE_EXCLUDE:  return clip(t + b - 2 * t * b / 255);
      MODE_OVERLAY:  return over_ch(t, b);
      MODE_SOFT: begin
        m = (t >> 1) + 64;
        if (b < 128) return clip(2 * m * b / 255);
        return clip(255 - (2 * (255 - m) * (255 - b) + 254) / 255);
      end
      MODE_HARD:     return over_ch(b, t);
      MODE_DODGE:    return dodge_ch(t, b);
      MODE_BURN:     return burn_ch(t, b);
      MODE_LLIGHT: begin
        if (b < 128) return clip(t + 2 * b - 255);
        return clip(t + 2 * (b - 128));
      end
      MODE_VIVID:    return vivid_ch(t, b);
      MODE_PIN: begin
        if (b < 128) return t < 2 * b ? t : 2 * b;
        return t > 2 * (b - 128) ? t : 2 * (b - 128);
      end
      MODE_HARDMIX:  return vivid_ch(t, b) < 128 ? 0 : 255;
      MODE_REFLECT:  return refl_ch(t, b);
      MODE_GLOW:     return refl_ch(b, t);
      MODE_PHOENIX:  return clip((t < b ? t : b) - (t > b ? t : b) + 255);
      default:       return t;
    endcase
  endfunction

  function automatic int weigh(int a, int c, int b);
    if (!cur_alpha) return c;
    return (a * c + (255 - a) * b) / 255;
  endfunction

  function automatic pix_out_t blend_pixel(pix_pair_t p);
    pix_out_t o;
    o.r = 8'(weigh(p.ta, mix_channel(cur_mode, p.tr, p.br), p.br));
    o.g = 8'(weigh(p.ta, mix_channel(cur_mode, p.tg, p.bg), p.bg));
    o.b = 8'(weigh(p.ta, mix_channel(cur_mode, p.tb, p.bb), p.bb));
    o.a = cur_alpha ? 8'((p.ta * p.ta + (255 - p.ta) * p.ba) / 255) : 8'd255;
    return o;
  endfunction

  // Idle with a chance of 12 in a hundred unless in a quiet stretch
  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 12);
  endfunction

  // Driver: present the next pending pair, predict at transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        blend_expect_q.push_back(blend_pixel({top_red, top_green, top_blue, top_alpha,
          bottom_red, bottom_green, bottom_blue, bottom_alpha}));
      end
      if ((!in_valid || in_ready) && pending_q.size() > 0 && !idle_now()) begin
        pix_pair_t p;
        p = pending_q.pop_front();
        {top_red, top_green, top_blue, top_alpha} <= {p.tr, p.tg, p.tb, p.ta};
        {bottom_red, bottom_green, bottom_blue, bottom_alpha} <= {p.br, p.bg, p.bb, p.ba};
        in_valid <= 1'b1;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each output transfer and drive out_ready
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (blend_expect_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected pixel %h%h%h%h", out_red, out_green,
                                    out_blue, out_alpha);
        end else begin
          pix_out_t e;
          e = blend_expect_q.pop_front();
          if ({out_red, out_green, out_blue, out_alpha} !== e) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch mode %0d alpha %0b: expected %h %h %h %h got %h %h %h %h",
                       cur_mode, cur_alpha, e.r, e.g, e.b, e.a,
                       out_red, out_green, out_blue, out_alpha);
          end
        end
      end
      if (hold_req) begin
        hold_left <= 300;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_now();
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [4:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BLEND_MODE) cur_mode = val;
    else cur_alpha = val[0];
  endtask

  // Sample between edges so queue and valid updates of the edge have settled
  task automatic drain();
    do @(negedge clk);
    while (pending_q.size() > 0 || in_valid || blend_expect_q.size() > 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  function automatic pix_pair_t rand_pair();
    pix_pair_t p;
    p = {$urandom, $urandom};
    // Bias toward edge values to hit branch boundaries
    if ($urandom_range(3) == 0) p.tr = $urandom_range(1) ? 8'd0 : 8'd255;
    if ($urandom_range(3) == 0) p.br = 8'd127 + 8'($urandom_range(2));
    if ($urandom_range(5) == 0) p.ta = $urandom_range(1) ? 8'd0 : 8'd255;
    return p;
  endfunction

  initial begin
    int edges[6] = '{0, 1, 127, 128, 254, 255};
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    in_valid = 1'b0; out_ready = 1'b0;
    {top_red, top_green, top_blue, top_alpha} = '0;
    {bottom_red, bottom_green, bottom_blue, bottom_alpha} = '0;
    cur_mode = MODE_NORMAL; cur_alpha = 1'b0;
    errors = 0; cycles = 0; hold_left = 0; hold_req = 0; quiet = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset mode with edge pairs, then every mode with 0/255/127/128 pairs
    for (int i = 0; i < 6; i++)
      pending_q.push_back({edges[i][7:0], edges[5-i][7:0], edges[i][7:0], edges[i][7:0],
                           edges[5-i][7:0], edges[i][7:0], 8'd255, edges[5-i][7:0]});
    drain();
    for (int m = 0; m < 32; m++) begin
      write_reg(REG_BLEND_MODE, 5'(m));
      write_reg(REG_ALPHA_ENABLE, 5'(m & 1));
      pending_q.push_back({8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd127, 8'd0});
      pending_q.push_back({8'd0, 8'd255, 8'd127, 8'd128, 8'd255, 8'd0, 8'd128, 8'd255});
      drain();
    end

    // Random phases over every mode, with alpha enable chosen at random
    for (int ph = 0; ph < 50; ph++) begin
      write_reg(REG_BLEND_MODE, ph < 25 ? 5'(ph) : 5'($urandom_range(31)));
      write_reg(REG_ALPHA_ENABLE, 5'($urandom_range(1)));
      quiet = (ph == 10);
      for (int i = 0; i < 20; i++) pending_q.push_back(rand_pair());
      if (ph == 20) begin
        // Stall the output while the sender keeps offering
        for (int i = 0; i < 40; i++) pending_q.push_back(rand_pair());
        @(posedge clk) hold_req <= 1'b1;
        @(posedge clk) hold_req <= 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
